[rtl/core/adbtx_pkg.sv]
package adbtx_pkg;

  // Default width of every timing register and of the segment counter
  localparam int TIME_BITS_DEFAULT = 12;

  // Register index width on the configuration port
  localparam int CFG_INDEX_BITS = 3;

  // Register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_ATTENTION = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SYNC      = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SHORT     = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LONG      = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_STOP      = 3'd4;

  // Timing register reset values in microsecond ticks
  localparam int RESET_ATTENTION = 800;
  localparam int RESET_SYNC      = 70;
  localparam int RESET_SHORT     = 35;
  localparam int RESET_LONG      = 65;
  localparam int RESET_STOP      = 65;

  // Frame phases
  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_ATTN = 3'd1;
  localparam logic [2:0] PH_SYNC = 3'd2;
  localparam logic [2:0] PH_BITS = 3'd3;
  localparam logic [2:0] PH_STOP = 3'd4;

  // Input item operations
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  typedef struct packed {
    logic       op;
    logic [7:0] command_byte;
  } cmd_t;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic frame_done;
  } res_t;

endpackage

[rtl/core/adbtx_frame.sv]
module adbtx_frame import adbtx_pkg::*; #(
  parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [TIME_BITS-1:0]      cfg_data,
  input  logic                      step,
  input  cmd_t                      item,
  output res_t                      result
);

  logic [TIME_BITS-1:0] attention_time;
  logic [TIME_BITS-1:0] sync_time;
  logic [TIME_BITS-1:0] short_time;
  logic [TIME_BITS-1:0] long_time;
  logic [TIME_BITS-1:0] stop_time;

  logic [2:0]           phase;
  logic [2:0]           phase_next;
  logic [TIME_BITS-1:0] phase_count;
  logic [TIME_BITS-1:0] phase_count_next;
  logic [2:0]           bit_number;
  logic [2:0]           bit_number_next;
  logic [7:0]           shift_bits;
  logic [7:0]           shift_bits_next;
  logic                 cell_half;
  logic                 cell_half_next;

  logic [TIME_BITS-1:0] count_inc;
  logic [TIME_BITS-1:0] seg_time;
  logic                 seg_end;
  logic                 done;
  logic                 line;

  // Write timing registers; writes to indexes outside the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      attention_time <= TIME_BITS'(RESET_ATTENTION);
      sync_time      <= TIME_BITS'(RESET_SYNC);
      short_time     <= TIME_BITS'(RESET_SHORT);
      long_time      <= TIME_BITS'(RESET_LONG);
      stop_time      <= TIME_BITS'(RESET_STOP);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ATTENTION: attention_time <= cfg_data;
        REG_SYNC:      sync_time      <= cfg_data;
        REG_SHORT:     short_time     <= cfg_data;
        REG_LONG:      long_time      <= cfg_data;
        REG_STOP:      stop_time      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pick the length of the current segment; a cell half is long when
  // the low half carries a zero or the high half carries a one
  always_comb begin
    case (phase)
      PH_ATTN: seg_time = attention_time;
      PH_SYNC: seg_time = sync_time;
      PH_BITS: seg_time = (cell_half == shift_bits[7]) ? long_time : short_time;
      PH_STOP: seg_time = stop_time;
      default: seg_time = sync_time;
    endcase
  end

  // Segment ends once the count reaches its length, or when the counter wraps
  assign count_inc = phase_count + 1'b1;
  assign seg_end   = (count_inc >= seg_time) || (count_inc == '0);

  // Advance the frame by one item
  always_comb begin
    phase_next       = phase;
    phase_count_next = phase_count;
    bit_number_next  = bit_number;
    shift_bits_next  = shift_bits;
    cell_half_next   = cell_half;
    done             = 1'b0;
    if (item.op == OP_START) begin
      if (phase == PH_IDLE) begin
        shift_bits_next  = item.command_byte;
        phase_next       = PH_ATTN;
        phase_count_next = '0;
        bit_number_next  = 3'd0;
        cell_half_next   = 1'b0;
      end
    end else begin
      phase_count_next = seg_end ? '0 : count_inc;
      unique case (phase)
        PH_IDLE: phase_count_next = phase_count;
        PH_ATTN: begin
          if (seg_end) phase_next = PH_SYNC;
        end
        PH_SYNC: begin
          if (seg_end) begin
            phase_next      = PH_BITS;
            bit_number_next = 3'd0;
            cell_half_next  = 1'b0;
          end
        end
        PH_BITS: begin
          if (seg_end) begin
            if (!cell_half) begin
              cell_half_next = 1'b1;
            end else begin
              cell_half_next  = 1'b0;
              shift_bits_next = {shift_bits[6:0], 1'b0};
              if (bit_number == 3'd7) begin
                bit_number_next = 3'd0;
                phase_next      = PH_STOP;
              end else begin
                bit_number_next = bit_number + 3'd1;
              end
            end
          end
        end
        PH_STOP: begin
          if (seg_end) begin
            phase_next = PH_IDLE;
            done       = 1'b1;
          end
        end
        default: begin
          phase_next       = PH_IDLE;
          phase_count_next = '0;
        end
      endcase
    end
  end

  // Hold frame state between transfers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      phase_count <= '0;
      bit_number  <= 3'd0;
      shift_bits  <= 8'd0;
      cell_half   <= 1'b0;
    end else if (step) begin
      phase       <= phase_next;
      phase_count <= phase_count_next;
      bit_number  <= bit_number_next;
      shift_bits  <= shift_bits_next;
      cell_half   <= cell_half_next;
    end
  end

  // Line level after this item
  always_comb begin
    case (phase_next)
      PH_ATTN: line = 1'b0;
      PH_SYNC: line = 1'b1;
      PH_BITS: line = cell_half_next;
      PH_STOP: line = 1'b0;
      default: line = 1'b1;
    endcase
  end

  assign result.line_level = line;
  assign result.busy_res   = (phase_next != PH_IDLE);
  assign result.frame_done = done;

endmodule

[rtl/core/adb_command_waveform_tx_unit.sv]
// Bus command transmitter: takes one item per clock while res_ready is high
// (a one-microsecond tick or a start carrying the command byte) and returns
// one result per item with the open-drain line level, busy and frame-done
// flags. The item is registered in the input register, then the frame state
// (phase, segment counter, bit counter, shift register) is updated once and
// the result is registered. While a result waits on res_ready the input
// register takes one more item and then holds cmd_ready low; when the result
// transfers, the staged item moves up and a new item is taken in that same
// cycle. A start item while a frame is in flight is ignored.
// Timing registers are written through the cfg port (always ready) and take
// effect on the next item.
module adb_command_waveform_tx_unit import adbtx_pkg::*; #(
  parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cmd_valid,
  output logic                      cmd_ready,
  input  cmd_t                      cmd,
  output logic                      res_valid,
  input  logic                      res_ready,
  output res_t                      res,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [TIME_BITS-1:0]      cfg_data
);

  logic stage_valid;
  cmd_t stage_item;
  logic advance;
  res_t result;

  assign cfg_ready = 1'b1;

  // Move the staged item into the result register when it is free
  assign advance   = stage_valid && (!res_valid || res_ready);
  assign cmd_ready = !stage_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (cmd_ready) begin
      stage_valid <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_ready) begin
      stage_item <= cmd;
    end
  end

  adbtx_frame #(
    .TIME_BITS (TIME_BITS)
  ) u_frame (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (advance),
    .item      (stage_item),
    .result    (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= result;
    end
  end

`ifndef ASSERT_OFF
  // An empty result register must never block the input side
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> cmd_ready)
    else $error("input stalled with empty result register");

  // A finished frame leaves the line released and the block idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.frame_done) |-> (!res.busy_res && res.line_level))
    else $error("frame done while still busy or line low");

  // No result appears right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid after reset");
`endif

endmodule

[verif/adb_command_waveform_tx_unit_tb.sv]
`timescale 1ns / 1ps

module adb_command_waveform_tx_unit_tb;
  import adbtx_pkg::*;

  localparam int TIME_W      = TIME_BITS_DEFAULT;
  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_CMDS = 1750;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cmd_valid = 1'b0;
  logic                      cmd_ready;
  cmd_t                      cmd = '0;
  logic                      res_valid;
  logic                      res_ready = 1'b0;
  res_t                      res;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [TIME_W-1:0]         cfg_data = '0;

  adb_command_waveform_tx_unit #(
    .TIME_BITS(TIME_W)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd      (cmd),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Commands waiting to be driven and line results waiting to be seen
  cmd_t cmd_backlog[$];
  res_t line_results_due[$];
  int   cmds_in_flight = 0;
  int   cmds_queued = 0;
  int   fault_count = 0;
  int   quiet_cycles = 0;
  bit   stall_enable = 1'b0;
  int   send_gap = 0;
  int   recv_gap = 0;

  // Shadow timing registers and frame state
  logic [TIME_W-1:0] t_attn  = TIME_W'(RESET_ATTENTION);
  logic [TIME_W-1:0] t_sync  = TIME_W'(RESET_SYNC);
  logic [TIME_W-1:0] t_short = TIME_W'(RESET_SHORT);
  logic [TIME_W-1:0] t_long  = TIME_W'(RESET_LONG);
  logic [TIME_W-1:0] t_stop  = TIME_W'(RESET_STOP);
  logic [2:0]        frame_phase = PH_IDLE;
  logic [TIME_W-1:0] seg_count = '0;
  logic [2:0]        bit_idx = '0;
  logic [7:0]        shifter = '0;
  logic              high_half = 1'b0;

  initial begin
    forever #2 clk = ~clk;
  end

  // Count one tick of the current segment; report when it ends
  function automatic logic count_segment(input logic [TIME_W-1:0] dur);
    logic [TIME_W-1:0] nxt;
    nxt = seg_count + 1'b1;
    if (nxt >= dur || nxt == '0) begin
      seg_count = '0;
      return 1'b1;
    end
    seg_count = nxt;
    return 1'b0;
  endfunction

  // Advance the shadow frame by one command and return the line result
  function automatic res_t predict_line(input cmd_t item);
    res_t              r;
    logic [TIME_W-1:0] dur;
    r = '0;
    if (item.op == OP_START) begin
      if (frame_phase == PH_IDLE) begin
        shifter     = item.command_byte;
        frame_phase = PH_ATTN;
        seg_count   = '0;
        bit_idx     = '0;
        high_half   = 1'b0;
      end
    end else begin
      case (frame_phase)
        PH_ATTN: begin
          if (count_segment(t_attn)) frame_phase = PH_SYNC;
        end
        PH_SYNC: begin
          if (count_segment(t_sync)) begin
            frame_phase = PH_BITS;
            bit_idx     = '0;
            high_half   = 1'b0;
          end
        end
        PH_BITS: begin
          // One cell: short low, long high; zero cell: long low, short high
          dur = (high_half == shifter[7]) ? t_long : t_short;
          if (count_segment(dur)) begin
            if (!high_half) begin
              high_half = 1'b1;
            end else begin
              high_half = 1'b0;
              shifter   = shifter << 1;
              if (bit_idx == 3'd7) begin
                bit_idx     = '0;
                frame_phase = PH_STOP;
              end else begin
                bit_idx = bit_idx + 1'b1;
              end
            end
          end
        end
        PH_STOP: begin
          if (count_segment(t_stop)) begin
            frame_phase  = PH_IDLE;
            r.frame_done = 1'b1;
          end
        end
        default: begin
          frame_phase = PH_IDLE;
          seg_count   = '0;
        end
      endcase
    end
    case (frame_phase)
      PH_ATTN, PH_STOP: r.line_level = 1'b0;
      PH_BITS:          r.line_level = high_half;
      default:          r.line_level = 1'b1;
    endcase
    r.busy_res = (frame_phase != PH_IDLE);
    return r;
  endfunction

  function automatic int seg_len(input logic [TIME_W-1:0] t);
    return (t == '0) ? 1 : int'(t);
  endfunction

  // Ticks needed for one whole frame at the current timing
  function automatic int frame_ticks();
    return seg_len(t_attn) + seg_len(t_sync) + 8 * (seg_len(t_short) + seg_len(t_long))
           + seg_len(t_stop);
  endfunction

  function automatic logic [TIME_W-1:0] pick_time();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r < 3) return TIME_W'($urandom_range(9, 40));
    return TIME_W'($urandom_range(1, 8));
  endfunction

  task automatic queue_cmd(input logic op, input logic [7:0] byte_val);
    cmd_t c;
    c.op           = op;
    c.command_byte = byte_val;
    cmd_backlog.push_back(c);
    cmds_in_flight++;
    cmds_queued++;
  endtask

  // Start a frame with a random byte, then tick it through (sometimes only partly), with stray starts
  task automatic send_frame();
    int ticks;
    int k;
    ticks = frame_ticks();
    if ($urandom_range(0, 7) == 0) ticks = $urandom_range(0, ticks);
    queue_cmd(OP_START, 8'($urandom));
    k = 0;
    while (k < ticks) begin
      if ($urandom_range(0, 39) == 0) begin
        queue_cmd(OP_START, 8'($urandom));
      end else begin
        queue_cmd(OP_TICK, 8'($urandom));
        k++;
      end
    end
    repeat ($urandom_range(0, 3)) queue_cmd(OP_TICK, 8'($urandom));
  endtask

  // Write one timing register and mirror it in the shadow copy
  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [TIME_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_ATTENTION: t_attn  = val;
      REG_SYNC:      t_sync  = val;
      REG_SHORT:     t_short = val;
      REG_LONG:      t_long  = val;
      REG_STOP:      t_stop  = val;
      default: ;
    endcase
  endtask

  // Hold until every command is taken and every result has come back
  task automatic wait_drain();
    do @(posedge clk); while (cmds_in_flight != 0 || line_results_due.size() != 0);
  endtask

  task automatic check_field(input string field, input logic exp_val, input logic act_val);
    if (act_val !== exp_val) begin
      $display("%0t: %s mismatch, expected %0b, actual %0b", $time, field, exp_val, act_val);
      fault_count++;
    end
  endtask

  // Command driver: hold valid until transfer, then pull the next command
  always @(posedge clk) begin
    logic nxt_valid;
    cmd_t nxt_cmd;
    nxt_valid = cmd_valid;
    nxt_cmd   = cmd;
    if (rst) begin
      nxt_valid = 1'b0;
    end else begin
      if (cmd_valid && cmd_ready) begin
        line_results_due.push_back(predict_line(cmd));
        cmds_in_flight--;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (cmd_backlog.size() > 0) begin
          nxt_cmd   = cmd_backlog.pop_front();
          nxt_valid = 1'b1;
          if (stall_enable && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 11);
        end
      end
    end
    cmd_valid <= nxt_valid;
    cmd       <= nxt_cmd;
  end

  // Result monitor: compare each transfer with the oldest prediction
  always @(posedge clk) begin
    logic nxt_ready;
    res_t due;
    if (!rst && res_valid && res_ready) begin
      if (line_results_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %b", $time, res);
        fault_count++;
      end else begin
        due = line_results_due.pop_front();
        check_field("line_level", due.line_level, res.line_level);
        check_field("busy_res", due.busy_res, res.busy_res);
        check_field("frame_done", due.frame_done, res.frame_done);
      end
    end
    if (recv_gap > 0) begin
      recv_gap--;
      nxt_ready = 1'b0;
    end else begin
      nxt_ready = 1'b1;
      if (stall_enable && $urandom_range(0, 7) == 0) recv_gap = $urandom_range(1, 11);
    end
    res_ready <= nxt_ready;
  end

  // Watchdog: end the run when no transfer happens for too long
  always @(posedge clk) begin
    if (rst || (cmd_valid && cmd_ready) || (res_valid && res_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int r;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Tick while idle, start at reset timing, start while busy is dropped
    stall_enable = 1'b1;
    queue_cmd(OP_TICK, 8'h00);
    queue_cmd(OP_START, 8'hFF);
    queue_cmd(OP_START, 8'h00);
    queue_cmd(OP_TICK, 8'hFF);
    wait_drain();

    // Largest timing everywhere, plus writes to unused indexes
    for (r = 0; r < 8; r++) write_reg(CFG_INDEX_BITS'(r), '1);
    queue_cmd(OP_TICK, 8'h00);
    queue_cmd(OP_TICK, 8'h00);
    wait_drain();

    // Shrink timing mid-frame, zero lengths included; run the frame out
    write_reg(REG_ATTENTION, '0);
    write_reg(REG_SYNC, TIME_W'(1));
    write_reg(REG_SHORT, '0);
    write_reg(REG_LONG, TIME_W'(1));
    write_reg(REG_STOP, '0);
    repeat (20) queue_cmd(OP_TICK, 8'($urandom));
    wait_drain();

    // Random timing per pass, frames with random bytes, no stalls at the end
    while (cmds_queued < RANDOM_CMDS) begin
      stall_enable = (cmds_queued < RANDOM_CMDS - 300) && ($urandom_range(0, 3) != 0);
      for (r = 0; r < 5; r++) begin
        if ($urandom_range(0, 1) == 1) write_reg(CFG_INDEX_BITS'(r), pick_time());
      end
      if ($urandom_range(0, 5) == 0) begin
        write_reg(CFG_INDEX_BITS'($urandom_range(5, 7)), TIME_W'($urandom));
      end
      repeat ($urandom_range(1, 4)) send_frame();
      wait_drain();
    end

    repeat (10) @(posedge clk);
    if (fault_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
